@@ hdl/assert_macros.svh @@
// assertion macros shared by the frame step pacer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising edge, off while reset is low
`define FSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define FSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fsp_pkg.sv @@
// frame step pacer package: widths, codes, reset values and control structs
// no dependencies; imported by every module and interface of the block
`default_nettype none

package fsp_pkg;

  localparam int STAMP_BITS = 32;
  localparam int COUNT_BITS = 16;

  localparam int ACC_W     = 40;
  localparam int STAMP_W   = 32;
  localparam int REG_W     = 32;
  localparam int OUT_W     = 16;
  localparam int STEP_W    = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DIFF_W = (STAMP_BITS > ACC_W) ? STAMP_BITS : ACC_W;
  localparam int PROD_W = COUNT_BITS + REG_W;

  localparam logic [REG_W-1:0] TPS_RESET   = 32'd1000000;
  localparam logic [REG_W-1:0] FIXED_RESET = 32'd16667;
  localparam logic [REG_W-1:0] MIN_RESET   = 32'd8333;

  localparam logic [CFG_IDX_W-1:0] CFG_TPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_FIXED   = 2'd1,
    KIND_CATCHUP = 2'd2,
    KIND_LATE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic restart;
    logic diff;
    logic add;
    logic roll;
    logic div_start;
    logic surp;
    logic emit_grant;
    logic emit_none;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_restart;
    logic is_paused;
    logic rollover;
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/fsp_if.sv @@
// valid/ready channel interfaces for tick words and result words
// depends on fsp_pkg for the field widths
`default_nettype none

interface fsp_tick_if;
  import fsp_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [STAMP_W-1:0] stamp;
  logic               paused;

  modport source (output valid, cmd, stamp, paused, input ready);
  modport sink   (input valid, cmd, stamp, paused, output ready);
endinterface

interface fsp_res_if;
  import fsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [STEP_W-1:0] step_ticks;
  logic [OUT_W-1:0]  steps_last_second;
  logic [OUT_W-1:0]  lates_last_second;
  logic [OUT_W-1:0]  late_rate;

  modport source (output valid, kind, step_ticks, steps_last_second,
                  lates_last_second, late_rate, input ready);
  modport sink   (input valid, kind, step_ticks, steps_last_second,
                  lates_last_second, late_rate, output ready);
endinterface

`default_nettype wire

@@ hdl/fsp_div.sv @@
// restoring divider for the late rate, one quotient bit a cycle
// depends on fsp_pkg; quotient is known to fit in COUNT_BITS bits
`default_nettype none
`include "assert_macros.svh"

module fsp_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [fsp_pkg::PROD_W-1:0]    dividend_i,
  input  wire logic [fsp_pkg::ACC_W-1:0]     divisor_i,
  output logic                               done_o,
  output logic [fsp_pkg::COUNT_BITS-1:0]     quot_o
);
  import fsp_pkg::*;

  localparam int DSH_W = ACC_W + COUNT_BITS;
  localparam int CNT_W = $clog2(COUNT_BITS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic                  zero_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DSH_W-1:0]      rem_q;
  logic [DSH_W-1:0]      dsh_q;
  logic [COUNT_BITS-1:0] q_q;
  logic                  take;

  assign take = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(COUNT_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DSH_W'(dividend_i);
      dsh_q  <= DSH_W'(divisor_i) << (COUNT_BITS - 1);
      zero_q <= (divisor_i == '0);
      q_q    <= '0;
    end else if (busy_q) begin
      if (take) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      q_q   <= {q_q[COUNT_BITS-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : q_q;

  `FSP_ASSERT_IMPL(a_div_start_idle, clk_i, rst_ni, start_i, !busy_q, "divider restarted while busy")

endmodule

`default_nettype wire

@@ hdl/fsp_datapath.sv @@
// datapath: config registers, accumulators, counters, grant logic, result register
// depends on fsp_pkg and fsp_div; driven by fsp_ctrl commands
`default_nettype none
`include "assert_macros.svh"

module fsp_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fsp_pkg::ctrl_cmd_t            cmd_i,
  output fsp_pkg::dp_sts_t                   sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fsp_pkg::REG_W-1:0]     cfg_data_i,
  input  wire logic                          in_cmd_i,
  input  wire logic [fsp_pkg::STAMP_W-1:0]   in_stamp_i,
  input  wire logic                          in_paused_i,
  output logic [fsp_pkg::KIND_W-1:0]         kind_o,
  output logic [fsp_pkg::STEP_W-1:0]         step_ticks_o,
  output logic [fsp_pkg::OUT_W-1:0]          steps_last_o,
  output logic [fsp_pkg::OUT_W-1:0]          lates_last_o,
  output logic [fsp_pkg::OUT_W-1:0]          late_rate_o
);
  import fsp_pkg::*;

  localparam int CAP_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [STEP_W-1:0]     STEP_MAX  = {STEP_W{1'b1}};
  localparam logic [OUT_W-1:0]      OUT_MAX   = {OUT_W{1'b1}};

  function automatic logic [OUT_W-1:0] cap_out(input logic [COUNT_BITS-1:0] v);
    logic [CAP_W-1:0] w;
    w = CAP_W'(v);
    if (w > CAP_W'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return w[OUT_W-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  // configuration
  logic [REG_W-1:0] tps_q, fix_q, min_q;

  // timing state
  logic [STAMP_BITS-1:0] last_q;
  logic [ACC_W-1:0]      elapsed_q, consumed_q;
  logic [COUNT_BITS-1:0] step_cnt_q, step_prev_q, late_cnt_q, late_prev_q;
  logic [OUT_W-1:0]      rate_q;
  logic                  marked_q;

  // captured word and intermediates
  logic                  cmd_q, paused_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic [DIFF_W-1:0]     diff_q;
  logic [ACC_W-1:0]      lim_q, surp_q, den_q;
  logic [PROD_W-1:0]     prod_q;

  // result register
  kind_e                 kind_q;
  logic [STEP_W-1:0]     step_q;
  logic [OUT_W-1:0]      steps_out_q, lates_out_q, rate_out_q;

  logic [STAMP_BITS-1:0] raw_diff;
  logic [ACC_W-1:0]      surplus_c, room_e, room_s, room_min, take_c, grant_c;
  logic                  fixed_ok, min_ok, div_done;
  logic [COUNT_BITS-1:0] quot;

  assign raw_diff  = stamp_q - last_q;
  assign surplus_c = elapsed_q - consumed_q;
  assign room_e    = ~elapsed_q;
  assign room_s    = ~surplus_c;
  assign room_min  = (room_e < room_s) ? room_e : room_s;
  assign take_c    = (diff_q > DIFF_W'(lim_q)) ? lim_q : diff_q[ACC_W-1:0];
  assign fixed_ok  = (surp_q >= ACC_W'(fix_q));
  assign min_ok    = (surp_q >= ACC_W'(min_q));
  assign grant_c   = (surp_q > ACC_W'(STEP_MAX)) ? ACC_W'(STEP_MAX) : surp_q;

  fsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= TPS_RESET;
      fix_q       <= FIXED_RESET;
      min_q       <= MIN_RESET;
      last_q      <= '0;
      elapsed_q   <= '0;
      consumed_q  <= '0;
      step_cnt_q  <= '0;
      step_prev_q <= '0;
      late_cnt_q  <= '0;
      late_prev_q <= '0;
      rate_q      <= '0;
      marked_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TPS:   tps_q <= cfg_data_i;
          CFG_FIXED: fix_q <= cfg_data_i;
          CFG_MIN:   min_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.restart) begin
        last_q     <= stamp_q;
        elapsed_q  <= '0;
        consumed_q <= '0;
        step_cnt_q <= '0;
        late_cnt_q <= '0;
        rate_q     <= '0;
      end
      if (cmd_i.diff) begin
        last_q <= stamp_q;
      end
      if (cmd_i.add) begin
        elapsed_q <= elapsed_q + take_c;
      end
      if (cmd_i.roll) begin
        step_prev_q <= step_cnt_q;
        step_cnt_q  <= '0;
        late_prev_q <= late_cnt_q;
        late_cnt_q  <= '0;
        elapsed_q   <= elapsed_q - ACC_W'(tps_q);
        consumed_q  <= consumed_q - ACC_W'(tps_q);
      end
      if (div_done) begin
        rate_q <= cap_out(quot);
      end
      if (cmd_i.emit_grant) begin
        if (fixed_ok) begin
          consumed_q <= consumed_q + ACC_W'(fix_q);
          step_cnt_q <= sat_inc(step_cnt_q);
          marked_q   <= 1'b0;
        end else if (min_ok) begin
          consumed_q <= consumed_q + grant_c;
          step_cnt_q <= sat_inc(step_cnt_q);
          marked_q   <= 1'b0;
        end else if (!marked_q) begin
          marked_q   <= 1'b1;
          late_cnt_q <= sat_inc(late_cnt_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= in_cmd_i;
      stamp_q  <= STAMP_BITS'(in_stamp_i);
      paused_q <= in_paused_i;
    end
    if (cmd_i.diff) begin
      diff_q <= DIFF_W'(raw_diff);
      lim_q  <= room_min;
    end
    if (cmd_i.roll) begin
      // rate divisor is the accumulator before the second is taken off
      prod_q <= PROD_W'(late_cnt_q) * PROD_W'(tps_q);
      den_q  <= elapsed_q;
    end
    if (cmd_i.surp) begin
      surp_q <= surplus_c;
    end
    if (cmd_i.emit_grant || cmd_i.emit_none) begin
      steps_out_q <= cap_out(step_prev_q);
      lates_out_q <= cap_out(late_prev_q);
      rate_out_q  <= rate_q;
      if (cmd_i.emit_grant && fixed_ok) begin
        kind_q <= KIND_FIXED;
        step_q <= fix_q;
      end else if (cmd_i.emit_grant && min_ok) begin
        kind_q <= KIND_CATCHUP;
        step_q <= grant_c[STEP_W-1:0];
      end else if (cmd_i.emit_grant && !marked_q) begin
        kind_q <= KIND_LATE;
        step_q <= '0;
      end else begin
        kind_q <= KIND_NONE;
        step_q <= '0;
      end
    end
  end

  assign sts_o.is_restart = cmd_q;
  assign sts_o.is_paused  = paused_q;
  assign sts_o.rollover   = (elapsed_q >= ACC_W'(tps_q));
  assign sts_o.div_done   = div_done;

  assign kind_o       = kind_q;
  assign step_ticks_o = step_q;
  assign steps_last_o = steps_out_q;
  assign lates_last_o = lates_out_q;
  assign late_rate_o  = rate_out_q;

  `FSP_ASSERT_NEXT(a_late_no_step, clk_i, rst_ni, cmd_i.emit_grant, (kind_q != KIND_LATE) || (step_q == '0), "late marker with a nonzero step")

endmodule

`default_nettype wire

@@ hdl/fsp_ctrl.sv @@
// controller: sequences one tick word through the datapath, owns result valid
// depends on fsp_pkg; commands fsp_datapath
`default_nettype none
`include "assert_macros.svh"

module fsp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire fsp_pkg::dp_sts_t   sts_i,
  output fsp_pkg::ctrl_cmd_t      cmd_o
);
  import fsp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_ADD,
    S_ROLL,
    S_DSTART,
    S_DIV,
    S_SURP,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   none_q;
  logic   out_valid_q;
  logic   out_free;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.restart    = (state_q == S_DIFF) && sts_i.is_restart;
    cmd_o.diff       = (state_q == S_DIFF) && !sts_i.is_restart && !sts_i.is_paused;
    cmd_o.add        = (state_q == S_ADD);
    cmd_o.roll       = (state_q == S_ROLL) && sts_i.rollover;
    cmd_o.div_start  = (state_q == S_DSTART);
    cmd_o.surp       = (state_q == S_SURP);
    cmd_o.emit_grant = (state_q == S_EMIT) && out_free && !none_q;
    cmd_o.emit_none  = (state_q == S_EMIT) && out_free && none_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      none_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (sts_i.is_restart || sts_i.is_paused) begin
            none_q  <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            none_q  <= 1'b0;
            state_q <= S_ADD;
          end
        end
        S_ADD:    state_q <= S_ROLL;
        S_ROLL:   state_q <= sts_i.rollover ? S_DSTART : S_SURP;
        S_DSTART: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_SURP;
          end
        end
        S_SURP:   state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `FSP_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd_o.emit_grant || cmd_o.emit_none, out_free, "result written over an untaken word")
  `FSP_ASSERT_IMPL(a_valid_from_emit, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_EMIT), "result valid raised outside emit")

endmodule

`default_nettype wire

@@ hdl/frame_step_pacer.sv @@
// top level of the frame step pacer: channel wiring, controller and datapath
// depends on fsp_pkg, fsp_if, fsp_ctrl, fsp_datapath (and fsp_div below it)
//
//   channel  dir  handshake     word
//   tick_i   in   valid/ready   cmd, stamp, paused
//   res_o    out  valid/ready   kind, step_ticks, steps/lates last second, late rate
//   cfg      in   cfg_we_i      cfg_idx_i selects register, cfg_data_i value
//
// one tick word at a time; ready only while the controller is idle
// restart or paused word: from the diff state straight to emit
// plain tick: diff, add, roll, surp and emit states; a one-second rollover adds the
//   dstart and div states for the restoring late-rate divider, one quotient bit a cycle
// a result waits in the output register; the next word is taken meanwhile and
//   holds in its last stage until the register is free
// reset is asynchronous active low and loads the register defaults
`default_nettype none

module frame_step_pacer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  fsp_tick_if.sink                           tick_i,
  fsp_res_if.source                          res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fsp_pkg::REG_W-1:0]     cfg_data_i
);
  import fsp_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer for one word, result valid lives here
  fsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_i.valid),
    .in_ready_o  (tick_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // accumulators, counters, divider and result payload
  fsp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (tick_i.cmd),
    .in_stamp_i   (tick_i.stamp),
    .in_paused_i  (tick_i.paused),
    .kind_o       (res_o.kind),
    .step_ticks_o (res_o.step_ticks),
    .steps_last_o (res_o.steps_last_second),
    .lates_last_o (res_o.lates_last_second),
    .late_rate_o  (res_o.late_rate)
  );

endmodule

`default_nettype wire
